// ===== rtl/core/att_pkg.sv =====
// Package for the annotation text tokenizer: token kinds, error codes, scan modes
// and the result and queue entry structs.
// No dependencies; every module of the block imports it.
package att_pkg;

   localparam int TOKEN_BITS  = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [3:0] KIND_ASSIGN = 4'd0;
   localparam logic [3:0] KIND_COMMA  = 4'd1;
   localparam logic [3:0] KIND_LBRACE = 4'd2;
   localparam logic [3:0] KIND_RBRACE = 4'd3;
   localparam logic [3:0] KIND_STRING = 4'd4;
   localparam logic [3:0] KIND_SYMBOL = 4'd5;
   localparam logic [3:0] KIND_INT    = 4'd6;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN = 2'd1;
   localparam logic [1:0] ERR_NUMBER  = 2'd2;
   localparam logic [1:0] ERR_STRING  = 2'd3;

   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_UP_X   = 8'h58;

   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_STRING = 5'b00010,
      MODE_SYMBOL = 5'b00100,
      MODE_NUMBER = 5'b01000,
      MODE_DROP   = 5'b10000
   } scan_mode_type;

   typedef enum logic [1:0] {
      CLASS_INT   = 2'd0,
      CLASS_HEX   = 2'd1,
      CLASS_FLOAT = 2'd2
   } num_class_type;

   typedef struct packed {
      logic [3:0]            kind;
      logic [TOKEN_BITS-1:0] start;
      logic [TOKEN_BITS-1:0] length;
      logic [1:0]            err;
      logic                  eot;
   } tok_result_type;

   // One queue entry: all results of one input byte (one or two).
   typedef struct packed {
      logic           pair;
      tok_result_type first;
      tok_result_type second;
   } tok_entry_type;

endpackage

// ===== rtl/core/att_front.sv =====
// Front end of the tokenizer: classifies each accepted byte, keeps the scan state
// and builds the one or two results that the byte causes.
// Depends on att_pkg.
module att_front #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             text_byte,
   input  logic                   last_byte,
   output logic                   push_valid,
   output att_pkg::tok_entry_type push_entry
);
   import att_pkg::*;

   scan_mode_type         mode_ff, mode_in;
   num_class_type         cls_ff, cls_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic                  odd_ff, odd_in;

   scan_mode_type          scan_mode;
   num_class_type          scan_cls;
   logic [OFFSET_BITS-1:0] scan_start;
   logic                   scan_odd;
   logic [OFFSET_BITS-1:0] len, pos_next, tail_len;
   logic                   rescan;
   logic                   close_v, idle_v, tail_v, pair;
   tok_result_type         close_r, idle_r, tail_r, first_r, second_r;

   function automatic logic is_blank(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [OFFSET_BITS-1:0] sat_next(input logic [OFFSET_BITS-1:0] p);
      return (&p) ? p : p + 1'b1;
   endfunction

   function automatic tok_result_type mk(input logic [3:0] k,
                                         input logic [OFFSET_BITS-1:0] s,
                                         input logic [OFFSET_BITS-1:0] l,
                                         input logic [1:0] e);
      tok_result_type r;
      r.kind   = k;
      r.start  = TOKEN_BITS'(s);
      r.length = TOKEN_BITS'(l);
      r.err    = e;
      r.eot    = 1'b0;
      return r;
   endfunction

   always_comb begin
      scan_mode  = mode_ff;
      scan_cls   = cls_ff;
      scan_start = start_ff;
      scan_odd   = odd_ff;
      rescan     = 1'b0;
      close_v    = 1'b0;
      close_r    = '0;
      idle_v     = 1'b0;
      idle_r     = '0;
      tail_v     = 1'b0;
      tail_r     = '0;
      len        = (pos_ff >= start_ff) ? pos_ff - start_ff : '0;

      // continue or close the open token
      case (mode_ff)
         MODE_STRING: begin
            if (text_byte == CH_QUOTE && !odd_ff) begin
               close_v   = 1'b1;
               close_r   = mk(KIND_STRING, start_ff, len, ERR_NONE);
               scan_mode = MODE_IDLE;
            end else if (text_byte == CH_BSLASH) begin
               scan_odd = ~odd_ff;
            end else begin
               scan_odd = 1'b0;
            end
         end
         MODE_SYMBOL: begin
            if (is_blank(text_byte) || text_byte == CH_COLON || text_byte == CH_EQUAL ||
                text_byte == CH_RBRACE) begin
               close_v = 1'b1;
               close_r = mk(KIND_SYMBOL, start_ff, len, ERR_NONE);
               rescan  = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_hex(text_byte) || text_byte == CH_DOT || text_byte == CH_LOW_X ||
                text_byte == CH_UP_X) begin
               if (text_byte == CH_DOT || text_byte == CH_LOW_X || text_byte == CH_UP_X) begin
                  if (cls_ff != CLASS_INT) begin
                     close_v = 1'b1;
                     close_r = mk(KIND_ASSIGN, start_ff, len, ERR_NUMBER);
                     rescan  = 1'b1;
                  end else begin
                     scan_cls = (text_byte == CH_DOT) ? CLASS_FLOAT : CLASS_HEX;
                  end
               end
            end else begin
               close_v = 1'b1;
               close_r = mk(KIND_INT + 4'(cls_ff), start_ff, len, ERR_NONE);
               rescan  = 1'b1;
            end
         end
         MODE_DROP: begin
         end
         default: begin
            rescan = 1'b1;
         end
      endcase

      // scan the byte as the start of a new token
      if (rescan) begin
         scan_mode = MODE_IDLE;
         if (text_byte == CH_COLON || text_byte == CH_EQUAL) begin
            idle_v = 1'b1;
            idle_r = mk(KIND_ASSIGN, pos_ff, OFFSET_BITS'(1), ERR_NONE);
         end else if (text_byte == CH_COMMA) begin
            idle_v = 1'b1;
            idle_r = mk(KIND_COMMA, pos_ff, OFFSET_BITS'(1), ERR_NONE);
         end else if (text_byte == CH_LBRACE) begin
            idle_v = 1'b1;
            idle_r = mk(KIND_LBRACE, pos_ff, OFFSET_BITS'(1), ERR_NONE);
         end else if (text_byte == CH_RBRACE) begin
            idle_v = 1'b1;
            idle_r = mk(KIND_RBRACE, pos_ff, OFFSET_BITS'(1), ERR_NONE);
         end else if (text_byte == CH_QUOTE) begin
            scan_mode  = MODE_STRING;
            scan_start = sat_next(pos_ff);
            scan_odd   = 1'b0;
         end else if (is_blank(text_byte)) begin
            scan_mode = MODE_IDLE;
         end else if (text_byte == CH_UNDER || is_alpha(text_byte)) begin
            scan_mode  = MODE_SYMBOL;
            scan_start = pos_ff;
         end else if (text_byte == CH_DOT || is_digit(text_byte)) begin
            scan_mode  = MODE_NUMBER;
            scan_start = pos_ff;
            scan_cls   = (text_byte == CH_DOT) ? CLASS_FLOAT : CLASS_INT;
         end else begin
            idle_v     = 1'b1;
            idle_r     = mk(KIND_ASSIGN, pos_ff, OFFSET_BITS'(1), ERR_UNKNOWN);
            idle_r.eot = 1'b1;
            scan_mode  = MODE_DROP;
         end
      end

      // flush a token still open at the last byte
      pos_next = sat_next(pos_ff);
      tail_len = (pos_next >= scan_start) ? pos_next - scan_start : '0;
      if (last_byte) begin
         case (scan_mode)
            MODE_STRING: begin
               tail_v = 1'b1;
               tail_r = mk(KIND_ASSIGN, scan_start, tail_len, ERR_STRING);
            end
            MODE_SYMBOL: begin
               tail_v = 1'b1;
               tail_r = mk(KIND_SYMBOL, scan_start, tail_len, ERR_NONE);
            end
            MODE_NUMBER: begin
               tail_v = 1'b1;
               tail_r = mk(KIND_INT + 4'(scan_cls), scan_start, tail_len, ERR_NONE);
            end
            default: begin
               tail_v = 1'b0;
            end
         endcase
      end

      // pack the results in order
      first_r  = close_v ? close_r : (idle_v ? idle_r : tail_r);
      second_r = (close_v && idle_v) ? idle_r : tail_r;
      pair     = (close_v && idle_v) || ((close_v || idle_v) && tail_v);
      if (last_byte) begin
         if (pair) begin
            second_r.eot = 1'b1;
         end else begin
            first_r.eot = 1'b1;
         end
      end

      if (last_byte) begin
         mode_in  = MODE_IDLE;
         cls_in   = CLASS_INT;
         start_in = '0;
         pos_in   = '0;
         odd_in   = 1'b0;
      end else begin
         mode_in  = scan_mode;
         cls_in   = scan_cls;
         start_in = scan_start;
         pos_in   = pos_next;
         odd_in   = scan_odd;
      end
   end

   assign push_valid        = accept && (close_v || idle_v || tail_v);
   assign push_entry.pair   = pair;
   assign push_entry.first  = first_r;
   assign push_entry.second = second_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cls_ff   <= CLASS_INT;
         start_ff <= '0;
         pos_ff   <= '0;
         odd_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         cls_ff   <= cls_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         odd_ff   <= odd_in;
      end
   end

endmodule

// ===== rtl/core/att_queue.sv =====
// Short queue between the tokenizer front and back: one entry per byte that
// causes results. Depends on att_pkg.
module att_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  att_pkg::tok_entry_type push_entry,
   output logic                   full,
   output logic                   head_valid,
   output att_pkg::tok_entry_type head_entry,
   input  logic                   pop
);
   import att_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   tok_entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ff, wr_in;
   logic [PTR_BITS-1:0]  rd_ff, rd_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == CNT_BITS'($past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

// ===== rtl/core/att_back.sv =====
// Back end of the tokenizer: splits queue entries into single results and holds
// each in an output register until taken. Depends on att_pkg.
module att_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  att_pkg::tok_entry_type head_entry,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output att_pkg::tok_result_type out_result,
   output logic                   out_last
);
   import att_pkg::*;

   logic           sel_ff, sel_in;
   logic           valid_ff, valid_in;
   tok_result_type res_ff, res_in;
   logic           last_ff, last_in;
   logic           load, final_one;

   assign load      = !valid_ff || out_ready;
   assign final_one = sel_ff || !head_entry.pair;
   assign pop       = load && head_valid && final_one;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      res_in   = res_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            res_in  = sel_ff ? head_entry.second : head_entry.first;
            last_in = final_one;
            sel_in  = !final_one;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = res_ff;
   assign out_last   = last_ff;

`ifndef SYNTH
   a_eot_is_final: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && res_ff.eot) |-> last_ff)
      else $error("end of text on a result that is not the byte's final one");
`endif

endmodule

// ===== rtl/core/annotation_text_tokenizer_top.sv =====
// Top level of the annotation text tokenizer: front classifier, result queue and
// output stage. Depends on att_pkg, att_front, att_queue and att_back.
//
//   channel | dir | tdata                          | tlast        | tuser
//   --------+-----+--------------------------------+--------------+-----------------------
//   req     | in  | text_byte                      | last_byte    | -
//   rsp     | out | token_kind, start, length      | end_of_text  | err_code, last_result
//
// One byte is taken per cycle while the four-entry queue has room; a byte that causes
// two results takes a single queue entry and holds the front only once the queue fills,
// since the back end sends one result per cycle while rsp_tready is high.
// Reset is synchronous, active high, and puts the scan state at offset 0.
// A stalled rsp side fills the queue, then drops req_tready; the front never waits
// on the back otherwise.
module annotation_text_tokenizer_top #(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] token_kind, [19:4] token_start,
                                    // [35:20] token_length, [39:36] zero
   output logic        rsp_tlast,   // end_of_text
   output logic [2:0]  rsp_tuser    // [1:0] err_code, [2] last_result
);
   import att_pkg::*;

   logic           accept;
   logic           push, full;
   tok_entry_type  push_entry, head_entry;
   logic           head_valid, pop;
   tok_result_type out_result;
   logic           out_last;

   // take a beat whenever the queue has room
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   att_front #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_tdata),
      .last_byte  (req_tlast),
      .push_valid (push),
      .push_entry (push_entry)
   );

   att_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   att_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result),
      .out_last   (out_last)
   );

   // pack the result beat, first field lowest
   assign rsp_tdata = {4'b0000, out_result.length, out_result.start, out_result.kind};
   assign rsp_tlast = out_result.eot;
   assign rsp_tuser = {out_last, out_result.err};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for annotation_text_tokenizer_top: drives annotation text byte by
// byte, predicts the token stream in-line and checks every result beat.
// Depends on att_pkg and the RTL of the block.
module tb_top;
   import att_pkg::*;

   localparam logic [3:0]  KIND_HEX       = 4'd7;
   localparam logic [3:0]  KIND_FLOAT     = 4'd8;
   localparam logic [7:0]  CH_SPACE       = 8'h20;
   localparam logic [7:0]  CH_TAB         = 8'h09;
   localparam logic [7:0]  CH_CR          = 8'h0D;
   localparam logic [7:0]  CH_LF          = 8'h0A;
   localparam logic [15:0] POS_MAX        = 16'hFFFF;
   localparam int          RANDOM_ITEMS   = 450;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 10;

   // One token as the rsp channel should carry it.
   typedef struct {
      logic [3:0]  kind;
      logic [15:0] offset;
      logic [15:0] span;
      logic [1:0]  err;
      logic        eot;
      logic        closes_byte;
   } token_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] text_byte
   logic        req_tlast  = 1'b0;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [3:0] kind, [19:4] start, [35:20] length, [39:36] zero
   logic        rsp_tlast;           // end_of_text
   logic [2:0]  rsp_tuser;           // [1:0] err_code, [2] last_result

   // Tokenizer state as the predictor tracks it.
   scan_mode_type scan_state = MODE_IDLE;
   num_class_type num_class  = CLASS_INT;
   logic [15:0]   tok_origin = 16'd0;
   logic [15:0]   byte_pos   = 16'd0;
   logic          bs_odd     = 1'b0;

   token_type expected_tokens[$];
   token_type byte_tokens[$];
   token_type want;

   int errors         = 0;
   int accepted_items = 0;
   int idle_cycles    = 0;
   int burst_left     = 0;
   int gap_max        = 4;

   logic [31:0] stall_mask  = 32'hFFFF_FFFF;
   logic [5:0]  stall_phase = 6'd0;

   string punct_chars = "{}:=,";
   string blank_chars = " \t\r\n";
   string alpha_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string hex_chars   = "0123456789abcdefABCDEF";

   annotation_text_tokenizer_top #(
      .OFFSET_BITS(16)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // Offsets stick at the top instead of wrapping.
   function automatic logic [15:0] pos_inc(logic [15:0] p);
      return (p == POS_MAX) ? p : p + 16'd1;
   endfunction

   task automatic add_token(input logic [3:0] kind, input logic [15:0] offset,
                            input logic [15:0] span, input logic [1:0] err, input logic eot);
      token_type t;
      t.kind        = kind;
      t.offset      = offset;
      t.span        = span;
      t.err         = err;
      t.eot         = eot;
      t.closes_byte = 1'b0;
      byte_tokens   = {byte_tokens, t};
   endtask

   // Scan a byte with no token open: one-character tokens come out at once, the
   // rest open a token or hit the unknown-character error (kind reads zero then).
   task automatic open_token(input logic [7:0] c, input logic [15:0] pos);
      if (c == CH_COLON || c == CH_EQUAL) begin
         add_token(KIND_ASSIGN, pos, 16'd1, ERR_NONE, 1'b0);
      end else if (c == CH_COMMA) begin
         add_token(KIND_COMMA, pos, 16'd1, ERR_NONE, 1'b0);
      end else if (c == CH_LBRACE) begin
         add_token(KIND_LBRACE, pos, 16'd1, ERR_NONE, 1'b0);
      end else if (c == CH_RBRACE) begin
         add_token(KIND_RBRACE, pos, 16'd1, ERR_NONE, 1'b0);
      end else if (c == CH_QUOTE) begin
         scan_state = MODE_STRING;
         tok_origin = pos_inc(pos);
         bs_odd     = 1'b0;
      end else if (is_blank(c)) begin
         // skip
      end else if (c == CH_UNDER || is_alpha(c)) begin
         scan_state = MODE_SYMBOL;
         tok_origin = pos;
      end else if (c == CH_DOT || is_digit(c)) begin
         scan_state = MODE_NUMBER;
         tok_origin = pos;
         num_class  = (c == CH_DOT) ? CLASS_FLOAT : CLASS_INT;
      end else begin
         add_token(KIND_ASSIGN, pos, 16'd1, ERR_UNKNOWN, 1'b1);
         scan_state = MODE_DROP;
      end
   endtask

   // Advance the predicted tokenizer by one accepted byte and queue its results.
   task automatic predict_byte(input logic [7:0] c, input bit last);
      logic [15:0] pos;
      logic [15:0] origin;
      logic [15:0] span;
      logic [15:0] next_pos;
      logic [3:0]  num_kind;
      pos      = byte_pos;
      origin   = tok_origin;
      span     = (pos >= origin) ? pos - origin : 16'd0;
      num_kind = KIND_INT + {2'b00, num_class};
      byte_tokens.delete();
      case (scan_state)
         MODE_STRING: begin
            if (c == CH_QUOTE && !bs_odd) begin
               add_token(KIND_STRING, origin, span, ERR_NONE, 1'b0);
               scan_state = MODE_IDLE;
            end else if (c == CH_BSLASH) begin
               bs_odd = !bs_odd;
            end else begin
               bs_odd = 1'b0;
            end
         end
         MODE_SYMBOL: begin
            // the closing byte is scanned again once the symbol is out
            if (is_blank(c) || c == CH_COLON || c == CH_EQUAL || c == CH_RBRACE) begin
               add_token(KIND_SYMBOL, origin, span, ERR_NONE, 1'b0);
               scan_state = MODE_IDLE;
               open_token(c, pos);
            end
         end
         MODE_NUMBER: begin
            if (c == CH_LOW_X || c == CH_UP_X || c == CH_DOT) begin
               // a second x or dot makes the number malformed; rescan the byte
               if (num_class != CLASS_INT) begin
                  add_token(KIND_ASSIGN, origin, span, ERR_NUMBER, 1'b0);
                  scan_state = MODE_IDLE;
                  open_token(c, pos);
               end else begin
                  num_class = (c == CH_DOT) ? CLASS_FLOAT : CLASS_HEX;
               end
            end else if (!is_hex(c)) begin
               add_token(num_kind, origin, span, ERR_NONE, 1'b0);
               scan_state = MODE_IDLE;
               open_token(c, pos);
            end
         end
         MODE_DROP: ;
         default: begin
            scan_state = MODE_IDLE;
            open_token(c, pos);
         end
      endcase
      if (last) begin
         // close whatever is still open, counting this byte too
         next_pos = pos_inc(pos);
         span     = (next_pos >= tok_origin) ? next_pos - tok_origin : 16'd0;
         num_kind = KIND_INT + {2'b00, num_class};
         if (scan_state == MODE_STRING)
            add_token(KIND_ASSIGN, tok_origin, span, ERR_STRING, 1'b0);
         else if (scan_state == MODE_SYMBOL)
            add_token(KIND_SYMBOL, tok_origin, span, ERR_NONE, 1'b0);
         else if (scan_state == MODE_NUMBER)
            add_token(num_kind, tok_origin, span, ERR_NONE, 1'b0);
         if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size()-1].eot = 1'b1;
         scan_state = MODE_IDLE;
         num_class  = CLASS_INT;
         tok_origin = 16'd0;
         byte_pos   = 16'd0;
         bs_odd     = 1'b0;
      end else begin
         byte_pos = pos_inc(pos);
      end
      if (byte_tokens.size() > 0)
         byte_tokens[byte_tokens.size()-1].closes_byte = 1'b1;
      expected_tokens = {expected_tokens, byte_tokens};
   endtask

   // ---------------------------------------------------------------- driving

   // Send one byte; the sender runs in bursts with random gaps between them.
   // Call at a rising edge; returns at the edge where the beat is taken.
   task automatic send_byte(input logic [7:0] c, input bit last);
      bit took;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gap_max > 0) begin
            gap = $urandom_range(1, gap_max);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      // sample ready mid-cycle so the edge itself decides nothing
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      // bytes dropped after an unknown character do not count as stimulus
      if (scan_state != MODE_DROP)
         accepted_items++;
      predict_byte(c, last);
   endtask

   task automatic send_text(input string s, input bit ends_text);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], ends_text && (i == s.len() - 1));
   endtask

   // Hold the sender until every expected token has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   // Receiver: each time the phase counter wraps, pick either a random stall mask or a clean run.
   always @(posedge clock) begin
      if (stall_phase == 6'd0)
         stall_mask <= ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
      stall_phase <= stall_phase + 6'd1;
      rsp_tready  <= stall_mask[stall_phase[4:0]];
   end

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (actual !== expected) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
      end
   endtask

   // Check each rsp beat against the oldest expected token, mid-cycle.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: unexpected token, expected none, got kind %0d start %0d len %0d",
                     $time, rsp_tdata[3:0], rsp_tdata[19:4], rsp_tdata[35:20]);
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", 32'(want.kind), 32'(rsp_tdata[3:0]));
            check_field("token_start", 32'(want.offset), 32'(rsp_tdata[19:4]));
            check_field("token_length", 32'(want.span), 32'(rsp_tdata[35:20]));
            check_field("tdata padding", 32'd0, 32'(rsp_tdata[39:36]));
            check_field("err_code", 32'(want.err), 32'(rsp_tuser[1:0]));
            check_field("end_of_text", 32'(want.eot), 32'(rsp_tlast));
            check_field("last_result", 32'(want.closes_byte), 32'(rsp_tuser[2]));
         end
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long.
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Symbol with a high byte closed by equals, hex closed by comma, x after x,
   // a symbol rescanned from the x, carriage return, closing brace as last byte.
   task automatic test_symbols_and_numbers();
      send_text("{a", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("=0x7,0xx.5\r}", 1'b1);
      wait_drained();
   endtask

   // Escaped quote, even backslash run before the closing quote, dot after dot,
   // x after dot, and a last byte that both rescans and closes a symbol.
   task automatic test_string_escapes();
      send_text("\"\\\"\\\\\",1..X", 1'b1);
      wait_drained();
   endtask

   // Float closed by a blank, int closed by an unknown byte; drop the rest.
   task automatic test_unknown_byte();
      send_text("1.5 12#", 1'b0);
      send_byte(8'h00, 1'b1);
      wait_drained();
   endtask

   task automatic test_unterminated_string();
      send_text("\"a", 1'b1);
      wait_drained();
   endtask

   // Mostly well-formed token sequences with random content, some noise and
   // texts cut off inside a token.
   task automatic test_random_texts();
      logic [7:0] text[$];
      int         base_count;
      int         pick;
      int         k;
      int         texts;
      base_count = accepted_items;
      texts      = 0;
      while (accepted_items - base_count < RANDOM_ITEMS) begin
         text.delete();
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               text = {text, punct_chars[$urandom_range(0, 4)]};
            end else if (pick < 32) begin
               text = {text, CH_QUOTE};
               repeat ($urandom_range(0, 6)) begin
                  k = $urandom_range(0, 9);
                  if (k < 2) begin
                     text = {text, CH_BSLASH};
                  end else if (k < 3) begin
                     text = {text, CH_BSLASH, CH_QUOTE};
                  end else if (k < 5) begin
                     text = {text, 8'($urandom_range(0, 255))};
                  end else begin
                     text = {text, alpha_chars[$urandom_range(0, 52)]};
                  end
               end
               text = {text, CH_QUOTE};
            end else if (pick < 55) begin
               text = {text, alpha_chars[$urandom_range(0, 52)]};
               repeat ($urandom_range(0, 7)) begin
                  k = $urandom_range(0, 9);
                  if (k < 6)
                     text = {text, alpha_chars[$urandom_range(0, 52)]};
                  else if (k < 8)
                     text = {text, hex_chars[$urandom_range(0, 9)]};
                  else
                     text = {text, 8'($urandom_range(0, 255))};
               end
            end else if (pick < 80) begin
               k = $urandom_range(0, 3);
               if (k == 1) begin
                  text = {text, hex_chars[0]};
                  text = {text, ($urandom_range(0, 1) != 0) ? CH_LOW_X : CH_UP_X};
               end else if (k == 2) begin
                  repeat ($urandom_range(0, 2))
                     text = {text, hex_chars[$urandom_range(0, 9)]};
                  text = {text, CH_DOT};
               end else if (k == 3) begin
                  // malformed: two markers in one number
                  text = {text, hex_chars[$urandom_range(0, 9)]};
                  text = {text, ($urandom_range(0, 1) != 0) ? CH_DOT : CH_LOW_X};
                  text = {text, hex_chars[$urandom_range(0, 21)]};
                  case ($urandom_range(0, 2))
                     0: text = {text, CH_DOT};
                     1: text = {text, CH_LOW_X};
                     default: text = {text, CH_UP_X};
                  endcase
               end else begin
                  text = {text, hex_chars[$urandom_range(0, 9)]};
               end
               repeat ($urandom_range(0, 4))
                  text = {text, hex_chars[$urandom_range(0, (k == 1) ? 21 : 9)]};
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 3))
                  text = {text, blank_chars[$urandom_range(0, 3)]};
            end else begin
               text = {text, 8'($urandom_range(0, 255))};
            end
            k = $urandom_range(0, 3);
            if (k == 0)
               text = {text, blank_chars[$urandom_range(0, 3)]};
            else if (k == 1)
               text = {text, punct_chars[$urandom_range(0, 4)]};
         end
         // cut some texts short so the last byte lands inside a token
         if ($urandom_range(0, 4) == 0 && text.size() > 1)
            text = text[0:$urandom_range(0, text.size() - 1)];
         case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 8;
         endcase
         foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
         texts++;
         if (texts % 6 == 0)
            wait_drained();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_symbols_and_numbers();
      test_string_escapes();
      test_unknown_byte();
      test_unterminated_string();
      test_random_texts();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/att_pkg.sv
rtl/core/att_front.sv
rtl/core/att_queue.sv
rtl/core/att_back.sv
rtl/core/annotation_text_tokenizer_top.sv
bench/tb_top.sv
